/* hdl/tilt_gesture_button_events_core_assert.svh */
// ----------------------------------------------------------------------------
// tilt gesture button events assertion macros
// concurrent check wrappers on clk with async active-low reset
// ----------------------------------------------------------------------------
`ifndef TILT_GESTURE_BUTTON_EVENTS_CORE_ASSERT_SVH
`define TILT_GESTURE_BUTTON_EVENTS_CORE_ASSERT_SVH

// same-cycle implication
`define TGB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TGB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/tgb_pkg.sv */
// ----------------------------------------------------------------------------
// tgb_pkg
// shared types, codes and the hold level evaluation for the tilt button core
// ----------------------------------------------------------------------------
package tgb_pkg;

    typedef logic [1:0] tilt_t;
    localparam tilt_t TILT_LEVEL = 2'b00;
    localparam tilt_t TILT_POS   = 2'b01;
    localparam tilt_t TILT_NEG   = 2'b11;

    localparam logic [2:0] BTN_NONE  = 3'd0;
    localparam logic [2:0] BTN_BACK  = 3'd1;
    localparam logic [2:0] BTN_RIGHT = 3'd2;
    localparam logic [2:0] BTN_LEFT  = 3'd3;
    localparam logic [2:0] BTN_FWD   = 3'd4;

    localparam logic [2:0] EV_RELEASE = 3'd0;
    localparam logic [2:0] EV_PRESS   = 3'd1;
    localparam logic [2:0] EV_SHORT   = 3'd2;
    localparam logic [2:0] EV_LONG    = 3'd3;
    localparam logic [2:0] EV_VERY    = 3'd4;
    localparam logic [2:0] EV_SUPER   = 3'd5;

    localparam logic [3:0] HOLD_NONE  = 4'd0;
    localparam logic [3:0] HOLD_SHORT = 4'd2;
    localparam logic [3:0] HOLD_LONG  = 4'd3;
    localparam logic [3:0] HOLD_VERY  = 4'd4;
    localparam logic [3:0] HOLD_SUPER = 4'd5;
    localparam logic [3:0] HOLD_STOP  = 4'd10;

    localparam logic [2:0] REG_TILT_ON    = 3'd0;
    localparam logic [2:0] REG_NEUTRAL    = 3'd1;
    localparam logic [2:0] REG_SETTLE     = 3'd2;
    localparam logic [2:0] REG_SHORT_HOLD = 3'd3;
    localparam logic [2:0] REG_LONG_HOLD  = 3'd4;
    localparam logic [2:0] REG_VERY_HOLD  = 3'd5;
    localparam logic [2:0] REG_SUPER_HOLD = 3'd6;

    localparam logic [14:0] RST_TILT_ON    = 15'd4096;
    localparam logic [14:0] RST_NEUTRAL    = 15'd2458;
    localparam logic [7:0]  RST_SETTLE     = 8'd10;
    localparam logic [31:0] RST_SHORT_HOLD = 32'd1000;
    localparam logic [31:0] RST_LONG_HOLD  = 32'd3000;
    localparam logic [31:0] RST_VERY_HOLD  = 32'd5000;
    localparam logic [31:0] RST_SUPER_HOLD = 32'd10000;

    typedef struct packed {
        logic [14:0] tilt_on_level;
        logic [14:0] neutral_level;
        logic [7:0]  settle_count;
        logic [31:0] short_hold_ms;
        logic [31:0] long_hold_ms;
        logic [31:0] very_long_hold_ms;
        logic [31:0] super_long_hold_ms;
    } cfg_t;

    typedef struct packed {
        logic [2:0] button_id;
        logic [2:0] event_kind;
        logic       last_event;
    } event_t;

    typedef struct packed {
        logic       fire;
        logic [3:0] level;
        logic [2:0] kind;
    } hold_res_t;

    function automatic hold_res_t hold_eval(input logic [31:0] d, input logic [3:0] level,
                                            input cfg_t cfg);
        hold_res_t r;
        r = '{fire: 1'b0, level: level, kind: EV_SHORT};
        if (d >= cfg.super_long_hold_ms && level < HOLD_SUPER)
        begin
            r = '{fire: 1'b1, level: HOLD_SUPER, kind: EV_SUPER};
        end
        else if (d >= cfg.very_long_hold_ms && level < HOLD_VERY)
        begin
            r = '{fire: 1'b1, level: HOLD_VERY, kind: EV_VERY};
        end
        else if (d >= cfg.long_hold_ms && level < HOLD_LONG)
        begin
            r = '{fire: 1'b1, level: HOLD_LONG, kind: EV_LONG};
        end
        else if (d >= cfg.short_hold_ms && level < HOLD_SHORT)
        begin
            r = '{fire: 1'b1, level: HOLD_SHORT, kind: EV_SHORT};
        end
        return r;
    endfunction

endpackage

/* hdl/tgb_axis_settle.sv */
// ----------------------------------------------------------------------------
// tgb_axis_settle
// hysteresis classifier and debounce counter for one acceleration axis
// ----------------------------------------------------------------------------
module tgb_axis_settle
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 update,
    input  logic signed [15:0]   accel,
    input  tgb_pkg::cfg_t        cfg,
    output tgb_pkg::tilt_t       tilt_next
);

    tgb_pkg::tilt_t    cand_reg, cand_next;
    tgb_pkg::tilt_t    rep_reg, rep_next;
    logic [7:0]        cnt_reg, cnt_next;
    logic [7:0]        cnt_base;
    logic signed [16:0] a_ext, on_ext, nl_ext;
    tgb_pkg::tilt_t    cls;

    assign a_ext  = {accel[15], accel};
    assign on_ext = $signed({2'b00, cfg.tilt_on_level});
    assign nl_ext = $signed({2'b00, cfg.neutral_level});

    always_comb
    begin
        if (a_ext <= -on_ext)
        begin
            cls = tgb_pkg::TILT_NEG;
        end
        else if (a_ext >= on_ext)
        begin
            cls = tgb_pkg::TILT_POS;
        end
        else if (a_ext > -nl_ext && a_ext < nl_ext)
        begin
            cls = tgb_pkg::TILT_LEVEL;
        end
        else
        begin
            cls = cand_reg;
        end
    end

    always_comb
    begin
        cand_next = cls;
        cnt_base  = (cls != cand_reg) ? 8'd0 : cnt_reg;
        cnt_next  = cnt_base;
        rep_next  = rep_reg;
        if (cnt_base < cfg.settle_count)
        begin
            cnt_next = cnt_base + 8'd1;
            if (cnt_next == cfg.settle_count)
            begin
                rep_next = cls;
            end
        end
    end

    assign tilt_next = rep_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= tgb_pkg::TILT_LEVEL;
            rep_reg  <= tgb_pkg::TILT_LEVEL;
            cnt_reg  <= 8'd0;
        end
        else if (update)
        begin
            cand_reg <= cand_next;
            rep_reg  <= rep_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

/* hdl/tgb_button_ctrl.sv */
// ----------------------------------------------------------------------------
// tgb_button_ctrl
// virtual button tracking: press, hold levels and release per word
// ----------------------------------------------------------------------------
module tgb_button_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid,
    input  logic             stop,
    input  tgb_pkg::tilt_t   y_tilt,
    input  tgb_pkg::tilt_t   z_tilt,
    input  logic [31:0]      now_ms,
    input  tgb_pkg::cfg_t    cfg,
    output logic [1:0]       ev_cnt,
    output tgb_pkg::event_t  ev [3]
);

    logic [2:0]  active_reg, active_next;
    logic [3:0]  level_reg, level_next;
    logic [31:0] press_time_reg, press_time_next;

    logic [7:0]  pressed;
    logic [4:1]  elig;
    logic        hit_a, rel, press;
    logic [2:0]  first;
    tgb_pkg::hold_res_t ho, hn;

    always_comb
    begin
        pressed    = 8'd0;
        pressed[1] = (z_tilt == tgb_pkg::TILT_NEG);
        pressed[2] = (y_tilt == tgb_pkg::TILT_NEG);
        pressed[3] = (y_tilt == tgb_pkg::TILT_POS);
        pressed[4] = (z_tilt == tgb_pkg::TILT_POS);
    end

    assign hit_a = pressed[active_reg];
    assign rel   = (active_reg != tgb_pkg::BTN_NONE) && !pressed[active_reg];

    always_comb
    begin
        first = tgb_pkg::BTN_NONE;
        for (int b = 4; b >= 1; b--)
        begin
            elig[b] = pressed[b] && (active_reg == tgb_pkg::BTN_NONE ||
                                     (rel && 3'(b) > active_reg));
            if (elig[b])
            begin
                first = 3'(b);
            end
        end
    end

    assign press = |elig;

    assign ho = tgb_pkg::hold_eval(now_ms - press_time_reg, level_reg, cfg);
    assign hn = tgb_pkg::hold_eval(32'd0, tgb_pkg::HOLD_NONE, cfg);

    // event list in emission order
    always_comb
    begin
        logic [1:0] idx;
        idx = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            ev[i] = '0;
        end
        if (!stop)
        begin
            if (rel && level_reg < tgb_pkg::HOLD_STOP)
            begin
                ev[idx] = '{button_id: active_reg, event_kind: tgb_pkg::EV_RELEASE,
                            last_event: 1'b0};
                idx = idx + 2'd1;
            end
            if (press)
            begin
                ev[idx] = '{button_id: first, event_kind: tgb_pkg::EV_PRESS,
                            last_event: 1'b0};
                idx = idx + 2'd1;
                if (hn.fire)
                begin
                    ev[idx] = '{button_id: first, event_kind: hn.kind, last_event: 1'b0};
                    idx = idx + 2'd1;
                end
            end
            if (hit_a && ho.fire)
            begin
                ev[idx] = '{button_id: active_reg, event_kind: ho.kind, last_event: 1'b0};
                idx = idx + 2'd1;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            ev[i].last_event = (2'(i) + 2'd1 == idx);
        end
        ev_cnt = idx;
    end

    always_comb
    begin
        active_next     = active_reg;
        level_next      = level_reg;
        press_time_next = press_time_reg;
        if (stop)
        begin
            level_next = tgb_pkg::HOLD_STOP;
        end
        else if (hit_a)
        begin
            if (ho.fire)
            begin
                level_next = ho.level;
            end
        end
        else if (press)
        begin
            active_next     = first;
            press_time_next = now_ms;
            level_next      = hn.fire ? hn.level : tgb_pkg::HOLD_NONE;
        end
        else if (rel)
        begin
            active_next = tgb_pkg::BTN_NONE;
            level_next  = tgb_pkg::HOLD_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= tgb_pkg::BTN_NONE;
            level_reg      <= tgb_pkg::HOLD_NONE;
            press_time_reg <= 32'd0;
        end
        else if (valid)
        begin
            active_reg     <= active_next;
            level_reg      <= level_next;
            press_time_reg <= press_time_next;
        end
    end

`include "tilt_gesture_button_events_core_assert.svh"

    `TGB_ASSERT_NEXT(a_stop_level, valid && stop, level_reg == tgb_pkg::HOLD_STOP, "stop not latched")
    `TGB_ASSERT_NEXT(a_press_take, valid && !stop && press, active_reg == $past(first) && press_time_reg == $past(now_ms), "press not taken")
    `TGB_ASSERT_NOW(a_hold_single, hit_a || stop, ev_cnt == 2'd0 || ev_cnt == 2'd1, "too many events for held or stopped button")

endmodule

/* hdl/tgb_event_queue.sv */
// ----------------------------------------------------------------------------
// tgb_event_queue
// three-entry result buffer draining one event word per cycle while pop_ready is high
// ----------------------------------------------------------------------------
module tgb_event_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [1:0]       load_cnt,
    input  tgb_pkg::event_t  load_ev [3],
    input  logic             pop_ready,
    output logic             can_load,
    output logic             head_valid,
    output tgb_pkg::event_t  head
);

    tgb_pkg::event_t ent_reg [3];
    tgb_pkg::event_t ent_next [3];
    logic [1:0]      cnt_reg, cnt_next;
    logic            pop;

    assign head_valid = (cnt_reg != 2'd0);
    assign head       = ent_reg[0];
    assign pop        = head_valid && pop_ready;
    assign can_load   = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop_ready);

    always_comb
    begin
        ent_next = ent_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            ent_next = load_ev;
            cnt_next = load_cnt;
        end
        else if (pop)
        begin
            ent_next[0] = ent_reg[1];
            ent_next[1] = ent_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

`include "tilt_gesture_button_events_core_assert.svh"

    `TGB_ASSERT_NOW(a_load_room, load, can_load, "load into busy queue")
    `TGB_ASSERT_NOW(a_tail_last, cnt_reg == 2'd1, ent_reg[0].last_event, "final entry lacks last flag")
    `TGB_ASSERT_NEXT(a_load_cnt, load, cnt_reg == $past(load_cnt), "queue count mismatch after load")

endmodule

/* hdl/tilt_gesture_button_events_core.sv */
// ----------------------------------------------------------------------------
// tilt_gesture_button_events_core
// tilt switch with debounce and hold detection on four virtual buttons
// ----------------------------------------------------------------------------
// s_axis carries one input word: tuser is func (1 = stop hold and release
// events of the current press), tdata holds accel_y, accel_z and now_ms.
// m_axis returns event words: tdata holds button_id and event_kind, tlast
// marks the final event caused by one input word. a word may cause zero to
// three events.
// cfg writes one register per handshake (index 0..6, others ignored); cfg is
// always ready and is meant to be written while the core is idle.
// the first event of a word passes the input register, then the result
// queue, before it appears on m_axis.
// throughput: one input word per cycle while words cause no events; a word
// with events holds the single result queue until its last event is taken
// on m_axis, and the input register waits on it.
// reset clears tilt state, buttons, hold level and press time and loads the
// register defaults. when m_axis stalls, the queue holds its words and the
// input register accepts one more word before s_axis_tready drops.
// ----------------------------------------------------------------------------
module tilt_gesture_button_events_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // accel_y[15:0], accel_z[31:16], now_ms[63:32]
    input  logic        s_axis_tuser,   // func

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // button_id[2:0], event_kind[5:3], zero[7:6]
    output logic        m_axis_tlast,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    tgb_pkg::cfg_t cfg_reg;

    logic               in_valid_reg;
    logic               in_stop_reg;
    logic signed [15:0] in_y_reg;
    logic signed [15:0] in_z_reg;
    logic [31:0]        in_now_reg;

    logic               can_load;
    logic               consume;
    tgb_pkg::tilt_t     y_tilt, z_tilt;
    logic [1:0]         ev_cnt;
    tgb_pkg::event_t    ev [3];
    tgb_pkg::event_t    head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tilt_on_level      <= tgb_pkg::RST_TILT_ON;
            cfg_reg.neutral_level      <= tgb_pkg::RST_NEUTRAL;
            cfg_reg.settle_count       <= tgb_pkg::RST_SETTLE;
            cfg_reg.short_hold_ms      <= tgb_pkg::RST_SHORT_HOLD;
            cfg_reg.long_hold_ms       <= tgb_pkg::RST_LONG_HOLD;
            cfg_reg.very_long_hold_ms  <= tgb_pkg::RST_VERY_HOLD;
            cfg_reg.super_long_hold_ms <= tgb_pkg::RST_SUPER_HOLD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tgb_pkg::REG_TILT_ON:    cfg_reg.tilt_on_level      <= cfg_data[14:0];
                tgb_pkg::REG_NEUTRAL:    cfg_reg.neutral_level      <= cfg_data[14:0];
                tgb_pkg::REG_SETTLE:     cfg_reg.settle_count       <= cfg_data[7:0];
                tgb_pkg::REG_SHORT_HOLD: cfg_reg.short_hold_ms      <= cfg_data;
                tgb_pkg::REG_LONG_HOLD:  cfg_reg.long_hold_ms       <= cfg_data;
                tgb_pkg::REG_VERY_HOLD:  cfg_reg.very_long_hold_ms  <= cfg_data;
                tgb_pkg::REG_SUPER_HOLD: cfg_reg.super_long_hold_ms <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // input register
    assign consume       = in_valid_reg && can_load;
    assign s_axis_tready = !in_valid_reg || can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_stop_reg <= s_axis_tuser;
            in_y_reg    <= s_axis_tdata[15:0];
            in_z_reg    <= s_axis_tdata[31:16];
            in_now_reg  <= s_axis_tdata[63:32];
        end
    end

    tgb_axis_settle u_axis_y
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .update    (consume && !in_stop_reg),
        .accel     (in_y_reg),
        .cfg       (cfg_reg),
        .tilt_next (y_tilt)
    );

    tgb_axis_settle u_axis_z
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .update    (consume && !in_stop_reg),
        .accel     (in_z_reg),
        .cfg       (cfg_reg),
        .tilt_next (z_tilt)
    );

    tgb_button_ctrl u_button
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (consume),
        .stop   (in_stop_reg),
        .y_tilt (y_tilt),
        .z_tilt (z_tilt),
        .now_ms (in_now_reg),
        .cfg    (cfg_reg),
        .ev_cnt (ev_cnt),
        .ev     (ev)
    );

    tgb_event_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (consume && ev_cnt != 2'd0),
        .load_cnt   (ev_cnt),
        .load_ev    (ev),
        .pop_ready  (m_axis_tready),
        .can_load   (can_load),
        .head_valid (m_axis_tvalid),
        .head       (head)
    );

    assign m_axis_tdata = {2'b00, head.event_kind, head.button_id};
    assign m_axis_tlast = head.last_event;

endmodule

/* sim/tilt_gesture_button_events_core_tb.sv */
// ----------------------------------------------------------------------------
// tilt_gesture_button_events_core_tb
// self-checking bench for the tilt switch core: a tracker class keeps its own
// copy of the axis debounce, button and hold state, works out the event words
// each accepted input word should cause and checks every event word in order.
// directed words hit the corner cases, then random gestures run under several
// register settings with random idling on both stream sides.
// ----------------------------------------------------------------------------
module tilt_gesture_button_events_core_tb;

    localparam int         AX_Y        = 0;
    localparam int         AX_Z        = 1;
    localparam logic [2:0] REG_UNUSED  = 3'd7;
    localparam int         DRAIN_TAIL  = 8;
    localparam int         STALL_LIMIT = 2000;

    class button_event_tracker;
        tgb_pkg::cfg_t      regs;
        tgb_pkg::tilt_t     reported [2];
        tgb_pkg::tilt_t     candidate [2];
        logic [7:0]         settle_cnt [2];
        logic [2:0]         active;
        logic [3:0]         level;
        logic [31:0]        press_ms;
        tgb_pkg::event_t    word_events [$];
        tgb_pkg::event_t    pending_events [$];
        int                 errors;
        int                 checked;

        function new();
            regs.tilt_on_level      = tgb_pkg::RST_TILT_ON;
            regs.neutral_level      = tgb_pkg::RST_NEUTRAL;
            regs.settle_count       = tgb_pkg::RST_SETTLE;
            regs.short_hold_ms      = tgb_pkg::RST_SHORT_HOLD;
            regs.long_hold_ms       = tgb_pkg::RST_LONG_HOLD;
            regs.very_long_hold_ms  = tgb_pkg::RST_VERY_HOLD;
            regs.super_long_hold_ms = tgb_pkg::RST_SUPER_HOLD;
            for (int i = 0; i < 2; i++)
            begin
                reported[i]   = tgb_pkg::TILT_LEVEL;
                candidate[i]  = tgb_pkg::TILT_LEVEL;
                settle_cnt[i] = 8'd0;
            end
            active   = tgb_pkg::BTN_NONE;
            level    = tgb_pkg::HOLD_NONE;
            press_ms = 32'd0;
            errors   = 0;
            checked  = 0;
        endfunction

        function int pending();
            return pending_events.size();
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                tgb_pkg::REG_TILT_ON:    regs.tilt_on_level      = data[14:0];
                tgb_pkg::REG_NEUTRAL:    regs.neutral_level      = data[14:0];
                tgb_pkg::REG_SETTLE:     regs.settle_count       = data[7:0];
                tgb_pkg::REG_SHORT_HOLD: regs.short_hold_ms      = data;
                tgb_pkg::REG_LONG_HOLD:  regs.long_hold_ms       = data;
                tgb_pkg::REG_VERY_HOLD:  regs.very_long_hold_ms  = data;
                tgb_pkg::REG_SUPER_HOLD: regs.super_long_hold_ms = data;
                default: ;
            endcase
        endfunction

        // tilt band first, then the strict level band, else keep the candidate
        function tgb_pkg::tilt_t classify(logic signed [15:0] accel, tgb_pkg::tilt_t keep);
            int v;
            int on;
            int nl;
            v  = accel;
            on = regs.tilt_on_level;
            nl = regs.neutral_level;
            if (v <= -on)
                return tgb_pkg::TILT_NEG;
            if (v >= on)
                return tgb_pkg::TILT_POS;
            if (v > -nl && v < nl)
                return tgb_pkg::TILT_LEVEL;
            return keep;
        endfunction

        function void settle_axis(int ax, logic [15:0] accel);
            tgb_pkg::tilt_t c;
            c = classify(accel, candidate[ax]);
            if (c != candidate[ax])
            begin
                candidate[ax]  = c;
                settle_cnt[ax] = 8'd0;
            end
            if (settle_cnt[ax] < regs.settle_count)
            begin
                settle_cnt[ax]++;
                if (settle_cnt[ax] == regs.settle_count)
                    reported[ax] = candidate[ax];
            end
        endfunction

        function bit held_down(logic [2:0] b);
            case (b)
                tgb_pkg::BTN_BACK:  return reported[AX_Z] == tgb_pkg::TILT_NEG;
                tgb_pkg::BTN_RIGHT: return reported[AX_Y] == tgb_pkg::TILT_NEG;
                tgb_pkg::BTN_LEFT:  return reported[AX_Y] == tgb_pkg::TILT_POS;
                default:            return reported[AX_Z] == tgb_pkg::TILT_POS;
            endcase
        endfunction

        function void add_event(logic [2:0] b, logic [2:0] kind);
            tgb_pkg::event_t ev;
            if (word_events.size() >= 3)
                return;
            ev.button_id  = b;
            ev.event_kind = kind;
            ev.last_event = 1'b0;
            word_events.push_back(ev);
        endfunction

        function void update_button(logic [2:0] b, logic [31:0] now);
            bit          p;
            logic [31:0] d;
            p = held_down(b);
            if (active == tgb_pkg::BTN_NONE && p)
            begin
                active   = b;
                level    = tgb_pkg::HOLD_NONE;
                press_ms = now;
                add_event(b, tgb_pkg::EV_PRESS);
            end
            if (active == b && p)
            begin
                // elapsed time wraps with the millisecond counter
                d = now - press_ms;
                if (d >= regs.super_long_hold_ms && level < tgb_pkg::HOLD_SUPER)
                begin
                    level = tgb_pkg::HOLD_SUPER;
                    add_event(b, tgb_pkg::EV_SUPER);
                end
                else if (d >= regs.very_long_hold_ms && level < tgb_pkg::HOLD_VERY)
                begin
                    level = tgb_pkg::HOLD_VERY;
                    add_event(b, tgb_pkg::EV_VERY);
                end
                else if (d >= regs.long_hold_ms && level < tgb_pkg::HOLD_LONG)
                begin
                    level = tgb_pkg::HOLD_LONG;
                    add_event(b, tgb_pkg::EV_LONG);
                end
                else if (d >= regs.short_hold_ms && level < tgb_pkg::HOLD_SHORT)
                begin
                    level = tgb_pkg::HOLD_SHORT;
                    add_event(b, tgb_pkg::EV_SHORT);
                end
            end
            if (active == b && !p)
            begin
                active = tgb_pkg::BTN_NONE;
                if (level < tgb_pkg::HOLD_STOP)
                    add_event(b, tgb_pkg::EV_RELEASE);
                level = tgb_pkg::HOLD_NONE;
            end
        endfunction

        function void take_word(logic func, logic [63:0] data);
            word_events.delete();
            // stop word: silence hold and release of the current press
            if (func)
            begin
                level = tgb_pkg::HOLD_STOP;
                return;
            end
            settle_axis(AX_Y, data[15:0]);
            settle_axis(AX_Z, data[31:16]);
            for (int b = tgb_pkg::BTN_BACK; b <= tgb_pkg::BTN_FWD; b++)
                update_button(3'(b), data[63:32]);
            if (word_events.size() > 0)
                word_events[word_events.size() - 1].last_event = 1'b1;
            foreach (word_events[i])
                pending_events.push_back(word_events[i]);
        endfunction

        function void compare(string field, int want, int got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void match_event(logic [7:0] data, logic last);
            tgb_pkg::event_t want;
            if (pending_events.size() == 0)
            begin
                errors++;
                $display("%0t: event word with none pending: button %0d kind %0d last %0b",
                         $time, data[2:0], data[5:3], last);
                return;
            end
            want = pending_events.pop_front();
            checked++;
            compare("button_id", want.button_id, data[2:0]);
            compare("event_kind", want.event_kind, data[5:3]);
            compare("last_event", want.last_event, last);
            compare("tdata pad", 0, data[7:6]);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    button_event_tracker tracker = new();

    bit          no_idle = 1'b0;
    int          stim_on = tgb_pkg::RST_TILT_ON;
    int          stim_nl = tgb_pkg::RST_NEUTRAL;
    int          stim_settle = tgb_pkg::RST_SETTLE;
    int          stim_step = 10;
    logic [31:0] sim_ms = 32'd0;
    int          words_sent = 0;
    int          stop_words = 0;
    int          reg_sets = 0;
    int          idle_cycles = 0;

    tilt_gesture_button_events_core u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        m_axis_tready <= no_idle || ($urandom_range(99) >= 22);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                tracker.match_event(m_axis_tdata, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                tracker.take_word(s_axis_tuser, s_axis_tdata);
            if (cfg_valid && cfg_ready)
                tracker.write_reg(cfg_index, cfg_data);
        end
    end

    always @(posedge clk)
    begin
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("tilt_gesture_button_events_core_tb: done, errors");
            $finish;
        end
    end

    task automatic send_word(input logic func, input logic [15:0] ay, input logic [15:0] az,
                             input logic [31:0] now_ms);
        while (!no_idle && $urandom_range(99) < 22)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = func;
        s_axis_tdata  = {now_ms, az, ay};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        words_sent++;
        if (func)
            stop_words++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_regs(input int on, input int nl, input int settle,
                            input logic [31:0] sh, input logic [31:0] lo,
                            input logic [31:0] vl, input logic [31:0] su,
                            input bit poke_unused);
        wait_drained();
        cfg_write(tgb_pkg::REG_TILT_ON, on);
        cfg_write(tgb_pkg::REG_NEUTRAL, nl);
        cfg_write(tgb_pkg::REG_SETTLE, settle);
        cfg_write(tgb_pkg::REG_SHORT_HOLD, sh);
        cfg_write(tgb_pkg::REG_LONG_HOLD, lo);
        cfg_write(tgb_pkg::REG_VERY_HOLD, vl);
        cfg_write(tgb_pkg::REG_SUPER_HOLD, su);
        if (poke_unused)
            cfg_write(REG_UNUSED, $urandom);
        cfg_valid   = 1'b0;
        stim_on     = on;
        stim_nl     = nl;
        stim_settle = settle;
        reg_sets++;
    endtask

    task automatic random_regs();
        int on;
        on = $urandom_range(20000, 1000);
        set_regs(on, $urandom_range(on, 1), $urandom_range(3, 1),
                 $urandom_range(200, 0), $urandom_range(200, 0),
                 $urandom_range(200, 0), $urandom_range(200, 0), 1'b0);
    endtask

    function automatic logic [15:0] tilt_val(input bit neg);
        int mag;
        mag = $urandom_range(32767, stim_on);
        if (!neg)
            return 16'(mag);
        if (mag == 32767 && $urandom_range(1) == 1)
            return 16'h8000;
        return 16'(-mag);
    endfunction

    function automatic logic [15:0] level_val();
        int mag;
        if (stim_nl == 0)
            return 16'h0000;
        mag = $urandom_range(stim_nl - 1, 0);
        return $urandom_range(1) ? 16'(-mag) : 16'(mag);
    endfunction

    // value between the level band and the tilt band
    function automatic logic [15:0] gap_val();
        int mag;
        if (stim_nl >= stim_on)
            return level_val();
        mag = $urandom_range(stim_on - 1, stim_nl);
        return $urandom_range(1) ? 16'(-mag) : 16'(mag);
    endfunction

    task automatic sample(input logic [15:0] ay, input logic [15:0] az);
        sim_ms = sim_ms + $urandom_range(stim_step, 0);
        send_word(1'b0, ay, az, sim_ms);
    endtask

    task automatic stop_word();
        send_word(1'b1, 16'($urandom), 16'($urandom), $urandom);
    endtask

    // tilt held for at least the settle count of samples (four when it exceeds twelve), then back to level
    task automatic gesture();
        int  kind;
        int  lead;
        int  i;
        bit  ys;
        bit  zs;
        kind = $urandom_range(5);
        ys   = $urandom_range(1);
        zs   = $urandom_range(1);
        lead = (stim_settle > 12) ? 4 : stim_settle;
        for (i = 0; i < lead + $urandom_range(5); i++)
        begin
            case (kind)
                0:       sample(level_val(), tilt_val(1'b1));
                1:       sample(tilt_val(1'b1), level_val());
                2:       sample(tilt_val(1'b0), level_val());
                3:       sample(level_val(), tilt_val(1'b0));
                4:       sample(tilt_val(ys), tilt_val(zs));
                default: sample(gap_val(), gap_val());
            endcase
            if ($urandom_range(99) < 6)
                stop_word();
        end
        for (i = 0; i < lead + $urandom_range(2); i++)
            sample(level_val(), level_val());
    endtask

    task automatic run_phase(input int count, input int step_max);
        int stop_at;
        int pick;
        stop_at   = words_sent + count;
        stim_step = step_max;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                gesture();
            else if (pick < 88)
                sample(16'($urandom), 16'($urandom));
            else
                stop_word();
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // one-sample settle, short hold ladder
        set_regs(4096, 2458, 1, 10, 20, 30, 40, 1'b0);
        send_word(1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(1'b0, 16'h0000, 16'h8000, 32'd100);
        send_word(1'b0, 16'h0000, 16'h8000, 32'd110);
        send_word(1'b0, 16'h0000, 16'h8000, 32'd120);
        send_word(1'b0, 16'h0000, 16'h8000, 32'd130);
        send_word(1'b0, 16'h0000, 16'h8000, 32'd140);
        send_word(1'b0, 16'h0000, 16'h8000, 32'd150);
        send_word(1'b0, 16'h0000, 16'h0000, 32'd160);
        // press just before the time wraps
        send_word(1'b0, 16'h7FFF, 16'h0000, 32'hFFFF_FFF0);
        send_word(1'b0, 16'h7FFF, 16'h0000, 32'h0000_0010);
        send_word(1'b1, 16'h8000, 16'h7FFF, 32'h0000_0000);
        send_word(1'b0, 16'h0000, 16'h0000, 32'h0000_0020);
        send_word(1'b0, 16'h8000, 16'h7FFF, 32'h0000_0030);
        // hysteresis gap keeps the tilt, then level releases it
        send_word(1'b0, 16'hF448, 16'h7FFF, 32'h0000_0030);
        send_word(1'b0, 16'hF667, 16'h7FFF, 32'h0000_0038);

        // zero settle count freezes the reported tilt
        set_regs(4096, 2458, 0, 10, 20, 30, 40, 1'b0);
        send_word(1'b0, 16'h7FFF, 16'h8000, 32'h0000_0040);
        send_word(1'b0, 16'h7FFF, 16'h8000, 32'h0000_0060);

        // zero tilt level: everything is tilted, zero counts as negative
        set_regs(0, 0, 1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_word(1'b0, 16'h0000, 16'h0000, 32'd100);
        send_word(1'b0, 16'h0000, 16'h0000, 32'd110);
        send_word(1'b0, 16'hFFFB, 16'h0001, 32'd120);
        send_word(1'b0, 16'h7FFF, 16'h7FFF, 32'd130);
        send_word(1'b1, 16'h0000, 16'h0000, 32'd135);
        send_word(1'b0, 16'h8000, 16'h7FFF, 32'd140);

        set_regs(tgb_pkg::RST_TILT_ON, tgb_pkg::RST_NEUTRAL, tgb_pkg::RST_SETTLE,
                 tgb_pkg::RST_SHORT_HOLD, tgb_pkg::RST_LONG_HOLD,
                 tgb_pkg::RST_VERY_HOLD, tgb_pkg::RST_SUPER_HOLD, 1'b0);
        run_phase(20, 400);

        set_regs(3000, 1500, 2, 40, 90, 150, 260, 1'b0);
        sim_ms = 32'hFFFF_FF00;
        run_phase(12, 40);
        wait_drained();
        run_phase(12, 40);

        random_regs();
        sim_ms  = $urandom;
        no_idle = 1'b1;
        run_phase(25, 50);
        no_idle = 1'b0;

        set_regs(32767, 32767, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 1'b0);
        run_phase(12, 100);

        set_regs(8000, 100, 255, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        run_phase(6, 10);

        random_regs();
        run_phase(25, 60);

        wait_drained();
        $display("covered %0d input words (%0d stop words) under %0d register settings",
                 words_sent, stop_words, reg_sets);
        $display("%0d event words checked, %0d mismatches", tracker.checked, tracker.errors);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("tilt_gesture_button_events_core_tb: done, clean");
        else
            $display("tilt_gesture_button_events_core_tb: done, errors");
        $finish;
    end

endmodule
